// ----- hdl/gitc_pkg.sv -----
// Shared types and constants of the gyro turn controller: item structs, register
// indexes, fixed-point constants and the microcode word with its field codes.
// No dependencies; imported by gitc_sequencer and the top level.
package gitc_pkg;

    // Input and result items.
    typedef struct packed {
        logic        op;
        logic [15:0] time_ms;
        logic [9:0]  gyro_raw;
    } in_item_t;

    typedef struct packed {
        logic signed [7:0] left_drive;
        logic signed [7:0] right_drive;
        logic              done_res;
        logic              timed_out;
    } out_item_t;

    localparam logic OP_START = 1'b0;

    // Configuration register indexes.
    localparam logic [2:0] CFG_TARGET   = 3'd0;
    localparam logic [2:0] CFG_BIAS     = 3'd1;
    localparam logic [2:0] CFG_GAIN     = 3'd2;
    localparam logic [2:0] CFG_MAX      = 3'd3;
    localparam logic [2:0] CFG_MIN      = 3'd4;
    localparam logic [2:0] CFG_LIMIT    = 3'd5;
    localparam logic [2:0] CFG_DEADBAND = 3'd6;
    localparam logic [2:0] CFG_TIMEOUT  = 3'd7;

    // Register values after reset.
    localparam logic signed [14:0] TARGET_RST   = 15'sd1440;
    localparam logic [13:0]        BIAS_RST     = 14'd9920;
    localparam logic [7:0]         GAIN_RST     = 8'd80;
    localparam logic [6:0]         MAX_RST      = 7'd60;
    localparam logic [6:0]         MIN_RST      = 7'd15;
    localparam logic [12:0]        LIMIT_RST    = 13'd2880;
    localparam logic [7:0]         DEADBAND_RST = 8'd3;
    localparam logic [15:0]        TIMEOUT_RST  = 16'd5000;

    // Fixed-point constants. The angle is held in 1/16 degree times 2000.
    localparam logic signed [7:0]  PRETENSION  = 8'sd5;
    localparam logic [26:0]        ANGLE_SCALE = 27'd2000;
    localparam logic signed [32:0] DONE_TOGO   = 33'sd96000;
    localparam logic signed [31:0] ACC_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ACC_MIN     = 32'sh8000_0000;
    // Division by 512000 is a shift by 12, then a multiply by ceil(2^21/125)
    // and a shift by 21, which is exact below SAT_LIMIT.
    localparam logic [26:0]        RECIP_125   = 27'd16778;
    localparam logic [32:0]        SAT_LIMIT   = 33'd16000;
    localparam logic [6:0]         SPEED_SAT   = 7'd127;

    // Microcode.
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_FETCH   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_LOAD    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_PRODUCT = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ACCUM   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_TOGO    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_TEST    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_SCALE   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_SPEED   = 4'd7;
    localparam logic [STEP_W-1:0] STEP_START   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_IDLE    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT    = 4'd15;

    localparam logic [3:0] AOP_NOP   = 4'd0;
    localparam logic [3:0] AOP_FETCH = 4'd1;
    localparam logic [3:0] AOP_LOAD  = 4'd2;
    localparam logic [3:0] AOP_ACCUM = 4'd3;
    localparam logic [3:0] AOP_TOGO  = 4'd4;
    localparam logic [3:0] AOP_TEST  = 4'd5;
    localparam logic [3:0] AOP_SCALE = 4'd6;
    localparam logic [3:0] AOP_SPEED = 4'd7;
    localparam logic [3:0] AOP_START = 4'd8;
    localparam logic [3:0] AOP_IDLE  = 4'd9;
    localparam logic [3:0] AOP_EMIT  = 4'd10;

    localparam logic [2:0] MUL_NONE      = 3'd0;
    localparam logic [2:0] MUL_DT_RSUM   = 3'd1;
    localparam logic [2:0] MUL_TARGET    = 3'd2;
    localparam logic [2:0] MUL_GAIN_TOGO = 3'd3;
    localparam logic [2:0] MUL_RECIP     = 3'd4;

    localparam logic [2:0] COND_NEVER    = 3'd0;
    localparam logic [2:0] COND_ALWAYS   = 3'd1;
    localparam logic [2:0] COND_NO_IN    = 3'd2;
    localparam logic [2:0] COND_START    = 3'd3;
    localparam logic [2:0] COND_FINISHED = 3'd4;
    localparam logic [2:0] COND_DONE     = 3'd5;
    localparam logic [2:0] COND_OUT_BUSY = 3'd6;

    typedef struct packed {
        logic [3:0]        aop;
        logic [2:0]        mul;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Status the datapath returns to the sequencer for its jumps.
    typedef struct packed {
        logic in_valid;
        logic op_start;
        logic finished;
        logic finish_hit;
        logic out_busy;
    } seq_flags_t;

endpackage

// ----- hdl/gitc_sequencer.sv -----
// Step counter and control store of the turn controller: one control word per
// step, with a conditional jump taken on datapath status. Depends on gitc_pkg.
module gitc_sequencer import gitc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  seq_flags_t flags,
    output ucode_t     ctrl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              jump;

    function automatic ucode_t rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        unique case (addr)
            STEP_FETCH:   w = '{aop: AOP_FETCH, mul: MUL_NONE, cond: COND_NO_IN,
                                target: STEP_FETCH};
            STEP_LOAD:    w = '{aop: AOP_LOAD, mul: MUL_NONE, cond: COND_START,
                                target: STEP_START};
            STEP_PRODUCT: w = '{aop: AOP_NOP, mul: MUL_DT_RSUM, cond: COND_FINISHED,
                                target: STEP_IDLE};
            STEP_ACCUM:   w = '{aop: AOP_ACCUM, mul: MUL_TARGET, cond: COND_NEVER,
                                target: STEP_FETCH};
            STEP_TOGO:    w = '{aop: AOP_TOGO, mul: MUL_NONE, cond: COND_NEVER,
                                target: STEP_FETCH};
            STEP_TEST:    w = '{aop: AOP_TEST, mul: MUL_GAIN_TOGO, cond: COND_DONE,
                                target: STEP_EMIT};
            STEP_SCALE:   w = '{aop: AOP_SCALE, mul: MUL_RECIP, cond: COND_NEVER,
                                target: STEP_FETCH};
            STEP_SPEED:   w = '{aop: AOP_SPEED, mul: MUL_NONE, cond: COND_ALWAYS,
                                target: STEP_EMIT};
            STEP_START:   w = '{aop: AOP_START, mul: MUL_NONE, cond: COND_ALWAYS,
                                target: STEP_EMIT};
            STEP_IDLE:    w = '{aop: AOP_IDLE, mul: MUL_NONE, cond: COND_ALWAYS,
                                target: STEP_EMIT};
            // The emit step is last, so falling through wraps to fetch.
            STEP_EMIT:    w = '{aop: AOP_EMIT, mul: MUL_NONE, cond: COND_OUT_BUSY,
                                target: STEP_EMIT};
            default:      w = '{aop: AOP_NOP, mul: MUL_NONE, cond: COND_ALWAYS,
                                target: STEP_FETCH};
        endcase
        return w;
    endfunction

    assign ctrl = rom(step_reg);

    always_comb begin
        unique case (ctrl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_IN:    jump = !flags.in_valid;
            COND_START:    jump = flags.op_start;
            COND_FINISHED: jump = flags.finished;
            COND_DONE:     jump = flags.finish_hit;
            COND_OUT_BUSY: jump = flags.out_busy;
            default:       jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_reg + 4'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= STEP_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- hdl/gyro_integrating_turn_controller.sv -----
// Top level of the gyro turn controller: configuration registers, datapath with
// one shared multiplier, and the result register. Depends on gitc_pkg and
// gitc_sequencer.
//
// Items enter on s_valid/s_ready/s_data and results leave on m_valid/m_ready/
// m_data, one result for every item. A start item (op 0) clears the angle and
// commands the pre-tension drive; a sample item (op 1) integrates the gyro rate
// and returns the drive, or done with zero drive once the turn is over.
// The configuration port writes register cfg_index from cfg_wdata whenever
// cfg_we is high; the user must write it only while the block is idle, and the
// block itself does not enforce this. After the fetch step a start item takes
// the load and start steps; a sample while idle takes load, product and idle;
// a sample that finishes the turn takes load, product, accumulate, to-go and
// test; a sample that drives the motors goes on through scale and speed. The
// microcode program passes four products in turn through the one multiplier.
// The next item is taken in the cycle after the emit step loads the result.
// Reset restores the register defaults, clears the angle and leaves the block
// finished, so samples report done until a start item arrives.
// A finished result waits in the output register while the next item is
// accepted and worked on; if the receiver still stalls when that second result
// is ready, the sequencer holds at its emit step and accepts nothing.
module gyro_integrating_turn_controller import gitc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    ucode_t     ctrl;
    seq_flags_t flags;

    // Configuration.
    logic signed [14:0] target_reg;
    logic [13:0]        bias_reg;
    logic [7:0]         gain_reg;
    logic [6:0]         max_reg;
    logic [6:0]         min_reg;
    logic [12:0]        limit_reg;
    logic [7:0]         deadband_reg;
    logic [15:0]        timeout_reg;

    // Turn state.
    logic signed [31:0] acc_reg, acc_next;
    logic signed [13:0] prev_rate_reg, prev_rate_next;
    logic [15:0]        prev_time_reg, prev_time_next;
    logic [15:0]        start_time_reg, start_time_next;
    logic               finished_reg, finished_next;
    logic               m_valid_reg, m_valid_next;

    // Working registers.
    in_item_t           in_reg, in_next;
    logic signed [13:0] rate_reg, rate_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [44:0] prod_reg, prod_next;
    logic signed [32:0] togo_reg, togo_next;
    logic               big_reg, big_next;
    out_item_t          res_reg, res_next;
    out_item_t          m_data_reg, m_data_next;

    // Datapath nets.
    logic               accept;
    logic               out_busy;
    logic signed [15:0] rate_raw, limit_s, rate_clip, rate_abs;
    logic [15:0]        dt_diff;
    logic signed [14:0] rate_sum;
    logic signed [15:0] target_wide, target_abs;
    logic signed [17:0] mul_a;
    logic signed [26:0] mul_b;
    logic signed [33:0] acc_sum;
    logic signed [32:0] acc_wide, acc_abs;
    logic [15:0]        elapsed;
    logic               near, late;
    logic [6:0]         spd_raw, spd_hi, spd_lo;
    logic signed [7:0]  spd_mag, drive;

    gitc_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    assign s_ready  = (ctrl.aop == AOP_FETCH);
    assign accept   = s_valid && s_ready;
    assign out_busy = m_valid_reg && !m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Rate: bias minus sixteen raw counts, clipped to the limit, then deadband.
    always_comb begin
        rate_raw = $signed({2'b00, bias_reg}) - $signed({2'b00, in_reg.gyro_raw, 4'b0000});
        limit_s  = $signed({3'b000, limit_reg});
        if (rate_raw > limit_s) begin
            rate_clip = limit_s;
        end else if (rate_raw < -limit_s) begin
            rate_clip = -limit_s;
        end else begin
            rate_clip = rate_raw;
        end
        rate_abs = rate_clip[15] ? -rate_clip : rate_clip;
        dt_diff  = in_reg.time_ms - prev_time_reg;
        rate_sum = $signed({rate_reg[13], rate_reg}) + $signed({prev_rate_reg[13], prev_rate_reg});
        target_wide = $signed({target_reg[14], target_reg});
        target_abs  = target_wide[15] ? -target_wide : target_wide;
        acc_sum  = $signed({{2{acc_reg[31]}}, acc_reg}) + $signed(prod_reg[33:0]);
        acc_wide = $signed({acc_reg[31], acc_reg});
        acc_abs  = acc_wide[32] ? -acc_wide : acc_wide;
        elapsed  = in_reg.time_ms - start_time_reg;
        near     = (togo_reg <= DONE_TOGO);
        late     = (elapsed > timeout_reg);
        // The scaled speed is seven bits wide below the saturation point.
        spd_raw  = big_reg ? SPEED_SAT : prod_reg[27:21];
        spd_hi   = (spd_raw > max_reg) ? max_reg : spd_raw;
        spd_lo   = (spd_hi < min_reg) ? min_reg : spd_hi;
        spd_mag  = $signed({1'b0, spd_lo});
        drive    = target_reg[14] ? -spd_mag : spd_mag;
    end

    // Shared multiplier operands.
    always_comb begin
        unique case (ctrl.mul)
            MUL_DT_RSUM: begin
                mul_a = $signed({2'b00, dt_reg});
                mul_b = $signed({{12{rate_sum[14]}}, rate_sum});
            end
            MUL_TARGET: begin
                mul_a = $signed({2'b00, target_abs});
                mul_b = $signed(ANGLE_SCALE);
            end
            MUL_GAIN_TOGO: begin
                mul_a = $signed({10'd0, gain_reg});
                mul_b = togo_reg[26:0];
            end
            MUL_RECIP: begin
                mul_a = $signed({4'd0, prod_reg[25:12]});
                mul_b = $signed(RECIP_125);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        in_next         = accept ? s_data : in_reg;
        rate_next       = rate_reg;
        dt_next         = dt_reg;
        prod_next       = (ctrl.mul == MUL_NONE) ? prod_reg : mul_a * mul_b;
        togo_next       = togo_reg;
        big_next        = big_reg;
        res_next        = res_reg;
        acc_next        = acc_reg;
        prev_rate_next  = prev_rate_reg;
        prev_time_next  = prev_time_reg;
        start_time_next = start_time_reg;
        finished_next   = finished_reg;
        m_data_next     = m_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        unique case (ctrl.aop)
            AOP_LOAD: begin
                rate_next = (rate_abs <= $signed({8'd0, deadband_reg})) ? '0 : rate_clip[13:0];
                dt_next   = (dt_diff == 16'd0) ? 16'd1 : dt_diff;
            end
            AOP_ACCUM: begin
                // The integral saturates at the signed 32-bit bounds.
                if (acc_sum[33:31] == 3'b000 || acc_sum[33:31] == 3'b111) begin
                    acc_next = acc_sum[31:0];
                end else if (acc_sum[33]) begin
                    acc_next = ACC_MIN;
                end else begin
                    acc_next = ACC_MAX;
                end
                prev_rate_next = rate_reg;
                prev_time_next = in_reg.time_ms;
            end
            AOP_TOGO: begin
                togo_next = $signed({7'd0, prod_reg[25:0]}) - acc_abs;
            end
            AOP_TEST: begin
                // The remaining angle takes precedence over the timeout.
                if (near || late) begin
                    finished_next        = 1'b1;
                    res_next.left_drive  = '0;
                    res_next.right_drive = '0;
                    res_next.done_res    = 1'b1;
                    res_next.timed_out   = !near;
                end
            end
            AOP_SCALE: begin
                big_next = (prod_reg[44:12] >= SAT_LIMIT);
            end
            AOP_SPEED: begin
                res_next.left_drive  = drive;
                res_next.right_drive = -drive;
                res_next.done_res    = 1'b0;
                res_next.timed_out   = 1'b0;
            end
            AOP_START: begin
                acc_next             = '0;
                prev_rate_next       = '0;
                prev_time_next       = in_reg.time_ms;
                start_time_next      = in_reg.time_ms;
                finished_next        = 1'b0;
                res_next.left_drive  = target_reg[14] ? PRETENSION : -PRETENSION;
                res_next.right_drive = target_reg[14] ? -PRETENSION : PRETENSION;
                res_next.done_res    = 1'b0;
                res_next.timed_out   = 1'b0;
            end
            AOP_IDLE: begin
                res_next.left_drive  = '0;
                res_next.right_drive = '0;
                res_next.done_res    = 1'b1;
                res_next.timed_out   = 1'b0;
            end
            AOP_EMIT: begin
                if (!out_busy) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        flags.in_valid   = s_valid;
        flags.op_start   = (in_reg.op == OP_START);
        flags.finished   = finished_reg;
        flags.finish_hit = near || late;
        flags.out_busy   = out_busy;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg     <= TARGET_RST;
            bias_reg       <= BIAS_RST;
            gain_reg       <= GAIN_RST;
            max_reg        <= MAX_RST;
            min_reg        <= MIN_RST;
            limit_reg      <= LIMIT_RST;
            deadband_reg   <= DEADBAND_RST;
            timeout_reg    <= TIMEOUT_RST;
            acc_reg        <= '0;
            prev_rate_reg  <= '0;
            prev_time_reg  <= '0;
            start_time_reg <= '0;
            finished_reg   <= 1'b1;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_TARGET:   target_reg   <= $signed(cfg_wdata[14:0]);
                    CFG_BIAS:     bias_reg     <= cfg_wdata[13:0];
                    CFG_GAIN:     gain_reg     <= cfg_wdata[7:0];
                    CFG_MAX:      max_reg      <= cfg_wdata[6:0];
                    CFG_MIN:      min_reg      <= cfg_wdata[6:0];
                    CFG_LIMIT:    limit_reg    <= cfg_wdata[12:0];
                    CFG_DEADBAND: deadband_reg <= cfg_wdata[7:0];
                    CFG_TIMEOUT:  timeout_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            acc_reg        <= acc_next;
            prev_rate_reg  <= prev_rate_next;
            prev_time_reg  <= prev_time_next;
            start_time_reg <= start_time_next;
            finished_reg   <= finished_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_reg     <= in_next;
        rate_reg   <= rate_next;
        dt_reg     <= dt_next;
        prod_reg   <= prod_next;
        togo_reg   <= togo_next;
        big_reg    <= big_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // A taken item moves the sequencer off its fetch step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("input still ready in the cycle after an item was taken");

    // A start step leaves a cleared angle and an unfinished turn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.aop == AOP_START) |=> (acc_reg == '0) && !finished_reg)
        else $error("start step did not clear the turn state");

    // A finished result carries zero drive.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.done_res) |-> (m_data.left_drive == '0)
            && (m_data.right_drive == '0))
        else $error("done result with non-zero drive");

    // The two sides always turn against each other.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.right_drive == -m_data.left_drive))
        else $error("right drive is not the negative of left drive");

    // A timeout is only reported on a finished turn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.timed_out || m_data.done_res))
        else $error("timeout flagged without done");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench of the gyro turn controller: directed turns, register
// extremes and random turns under four idling mixes and a long output stall.
// Depends on gitc_pkg and gyro_integrating_turn_controller.
module testbench;
    import gitc_pkg::*;

    localparam logic OP_SAMPLE   = ~OP_START;
    localparam int   CYCLE_LIMIT = 600000;
    localparam int   HOLD_CYCLES = 250;
    localparam int   PHASE_ITEMS = 215;
    localparam longint ACC_TOP    = 64'sd2147483647;
    localparam longint ACC_BOTTOM = -64'sd2147483648;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;

    // Our own copy of the registers and of the turn state.
    logic signed [14:0] turn_target;
    logic [13:0]        turn_bias;
    logic [7:0]         turn_gain;
    logic [6:0]         turn_max;
    logic [6:0]         turn_min;
    logic [12:0]        turn_limit;
    logic [7:0]         turn_deadband;
    logic [15:0]        turn_timeout;
    int                 angle_sum;
    int                 last_rate;
    logic [15:0]        last_ms;
    logic [15:0]        turn_start_ms;
    bit                 turn_over;

    out_item_t pending_commands[$];
    out_item_t want_cmd;
    logic [15:0] now_ms = '0;

    int sender_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int turns_started = 0;
    int angle_finishes = 0;
    int timeouts_seen = 0;

    gyro_integrating_turn_controller DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic out_item_t predict_command(in_item_t item);
        int          dir;
        int          rate;
        int          lim;
        int          left;
        logic [15:0] dt;
        logic [15:0] elapsed;
        longint      sum;
        longint      togo;
        longint      spd;
        out_item_t   cmd;
        dir = (turn_target < 0) ? -1 : 1;
        left = 0;
        cmd = '0;
        if (item.op == OP_START) begin
            angle_sum = 0;
            last_rate = 0;
            last_ms = item.time_ms;
            turn_start_ms = item.time_ms;
            turn_over = 1'b0;
            left = -dir * int'(PRETENSION);
            turns_started++;
        end else if (turn_over) begin
            cmd.done_res = 1'b1;
        end else begin
            rate = int'(turn_bias) - int'(item.gyro_raw) * 16;
            lim = int'(turn_limit);
            if (rate > lim) rate = lim;
            if (rate < -lim) rate = -lim;
            if (((rate < 0) ? -rate : rate) <= int'(turn_deadband)) rate = 0;
            dt = item.time_ms - last_ms;
            if (dt == 16'd0) dt = 16'd1;
            elapsed = item.time_ms - turn_start_ms;
            sum = longint'(angle_sum) + longint'(dt) * longint'(rate + last_rate);
            if (sum > ACC_TOP) sum = ACC_TOP;
            if (sum < ACC_BOTTOM) sum = ACC_BOTTOM;
            angle_sum = int'(sum);
            last_rate = rate;
            last_ms = item.time_ms;
            togo = ((turn_target < 0) ? -longint'(turn_target) : longint'(turn_target)) * 2000
                 - ((angle_sum < 0) ? -longint'(angle_sum) : longint'(angle_sum));
            // Within three degrees of the target counts as done.
            if (togo <= 96000) begin
                turn_over = 1'b1;
                cmd.done_res = 1'b1;
                angle_finishes++;
            end else if (elapsed > turn_timeout) begin
                turn_over = 1'b1;
                cmd.done_res = 1'b1;
                cmd.timed_out = 1'b1;
                timeouts_seen++;
            end else begin
                spd = (longint'(turn_gain) * togo) / 512000;
                if (spd > longint'(turn_max)) spd = longint'(turn_max);
                if (spd < longint'(turn_min)) spd = longint'(turn_min);
                left = dir * int'(spd);
            end
        end
        cmd.left_drive = 8'(left);
        cmd.right_drive = 8'(-left);
        return cmd;
    endfunction

    function automatic in_item_t make_item(logic op, logic [15:0] t, logic [9:0] raw);
        in_item_t item;
        item.op = op;
        item.time_ms = t;
        item.gyro_raw = raw;
        return item;
    endfunction

    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        case ($urandom_range(7))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // Results are checked in order at each accepted handshake; the receiver
    // stalls at random or for a requested stretch.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_commands.size() == 0) begin
                    $error("result item arrived with no item outstanding");
                    errors++;
                end else begin
                    want_cmd = pending_commands.pop_front();
                    results_checked++;
                    if (m_data.left_drive !== want_cmd.left_drive) begin
                        $error("left_drive: expected %0d, got %0d",
                               want_cmd.left_drive, m_data.left_drive);
                        errors++;
                    end
                    if (m_data.right_drive !== want_cmd.right_drive) begin
                        $error("right_drive: expected %0d, got %0d",
                               want_cmd.right_drive, m_data.right_drive);
                        errors++;
                    end
                    if (m_data.done_res !== want_cmd.done_res) begin
                        $error("done_res: expected %0d, got %0d",
                               want_cmd.done_res, m_data.done_res);
                        errors++;
                    end
                    if (m_data.timed_out !== want_cmd.timed_out) begin
                        $error("timed_out: expected %0d, got %0d",
                               want_cmd.timed_out, m_data.timed_out);
                        errors++;
                    end
                end
            end
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_item(input in_item_t item);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(12, 1) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= item;
        do @(posedge aclk); while (!s_ready);
        pending_commands.push_back(predict_command(item));
        items_sent++;
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_commands.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_TARGET:   turn_target = value[14:0];
            CFG_BIAS:     turn_bias = value[13:0];
            CFG_GAIN:     turn_gain = value[7:0];
            CFG_MAX:      turn_max = value[6:0];
            CFG_MIN:      turn_min = value[6:0];
            CFG_LIMIT:    turn_limit = value[12:0];
            CFG_DEADBAND: turn_deadband = value[7:0];
            CFG_TIMEOUT:  turn_timeout = value;
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all(input int target, input int bias, input int gain, input int max_s,
                             input int min_s, input int limit, input int deadband,
                             input int timeout);
        write_reg(CFG_TARGET, 16'(target));
        write_reg(CFG_BIAS, 16'(bias));
        write_reg(CFG_GAIN, 16'(gain));
        write_reg(CFG_MAX, 16'(max_s));
        write_reg(CFG_MIN, 16'(min_s));
        write_reg(CFG_LIMIT, 16'(limit));
        write_reg(CFG_DEADBAND, 16'(deadband));
        write_reg(CFG_TIMEOUT, 16'(timeout));
    endtask

    task automatic randomise_settings();
        int target;
        int timeout;
        if ($urandom_range(1) == 0) target = int'($urandom_range(4000)) - 2000;
        else target = int'(pick(0, 23040)) - 11520;
        if ($urandom_range(3) == 0) timeout = $urandom_range(3000, 100);
        else timeout = pick(0, 65535);
        write_all(target, pick(0, 16383), pick(0, 255), pick(0, 100), pick(0, 100),
                  pick(0, 8191), pick(0, 255), timeout);
    endtask

    // One turn: a start, then samples whose rate follows the turn direction,
    // with the odd stray item mixed in.
    task automatic run_turn();
        int n_samples;
        int step;
        int mag;
        int raw_i;
        n_samples = $urandom_range(60, 4);
        now_ms += 16'($urandom_range(200));
        send_item(make_item(OP_START, now_ms, 10'($urandom)));
        for (int k = 0; k < n_samples && !turn_over; k++) begin
            if ($urandom_range(19) == 0) begin
                send_item(make_item(1'($urandom), 16'($urandom), 10'($urandom)));
            end else begin
                case ($urandom_range(19))
                    0: step = 0;
                    1: step = $urandom_range(65535, 1000);
                    default: step = $urandom_range(200, 5);
                endcase
                now_ms += 16'(step);
                mag = $urandom_range(3000, 50);
                if (turn_target < 0) mag = -mag;
                raw_i = (int'(turn_bias) - mag) / 16 + int'($urandom_range(6)) - 3;
                if (raw_i < 0) raw_i = 0;
                if (raw_i > 1023) raw_i = 1023;
                send_item(make_item(OP_SAMPLE, now_ms, 10'(raw_i)));
            end
        end
        if (turn_over && $urandom_range(3) == 0)
            send_item(make_item(OP_SAMPLE, now_ms, 10'($urandom)));
    endtask

    task automatic test_reset_defaults();
        logic [15:0] t;
        // Samples before any start report done with no drive.
        send_item(make_item(OP_SAMPLE, 16'd0, 10'd0));
        send_item(make_item(OP_SAMPLE, 16'hFFFF, 10'h3FF));
        send_item(make_item(OP_START, 16'd100, 10'h3FF));
        send_item(make_item(OP_SAMPLE, 16'd100, 10'd620));
        send_item(make_item(OP_SAMPLE, 16'd115, 10'd0));
        send_item(make_item(OP_SAMPLE, 16'd130, 10'h3FF));
        t = 16'd130;
        for (int k = 0; k < 20 && !turn_over; k++) begin
            t += 16'd100;
            send_item(make_item(OP_SAMPLE, t, 10'd500));
        end
        send_item(make_item(OP_SAMPLE, t, 10'd500));
        // The elapsed time wraps; exactly the timeout still drives, one more ms gives up.
        send_item(make_item(OP_START, 16'd65000, 10'd0));
        send_item(make_item(OP_SAMPLE, 16'd4464, 10'd620));
        send_item(make_item(OP_SAMPLE, 16'd4465, 10'd620));
    endtask

    task automatic test_register_extremes();
        wait_idle();
        write_all(-11520, 16383, 255, 100, 0, 8191, 0, 65535);
        send_item(make_item(OP_START, 16'd0, 10'd0));
        send_item(make_item(OP_SAMPLE, 16'd1, 10'h3FF));
        send_item(make_item(OP_SAMPLE, 16'hFFFF, 10'd0));
        // Crossed clamps: the minimum speed wins over a zero maximum.
        wait_idle();
        write_all(11520, 0, 0, 0, 100, 0, 255, 0);
        send_item(make_item(OP_START, 16'd500, 10'd7));
        send_item(make_item(OP_SAMPLE, 16'd500, 10'h3FF));
        send_item(make_item(OP_SAMPLE, 16'd501, 10'd0));
        // A zero target is already within reach.
        wait_idle();
        write_all(0, 9920, 80, 60, 15, 2880, 3, 5000);
        send_item(make_item(OP_START, 16'd40, 10'd620));
        send_item(make_item(OP_SAMPLE, 16'd55, 10'd600));
        // Rates at and just above the deadband edge.
        wait_idle();
        write_all(1440, 9923, 80, 60, 15, 2880, 3, 5000);
        send_item(make_item(OP_START, 16'd0, 10'd620));
        send_item(make_item(OP_SAMPLE, 16'd10, 10'd620));
        wait_idle();
        write_reg(CFG_BIAS, 16'd9924);
        send_item(make_item(OP_SAMPLE, 16'd20, 10'd620));
    endtask

    task automatic test_random_traffic(input int s_pct, input int r_pct);
        int first;
        sender_idle_pct = s_pct;
        recv_stall_pct = r_pct;
        first = items_sent;
        while (items_sent - first < PHASE_ITEMS) begin
            if ($urandom_range(1) == 0) begin
                wait_idle();
                randomise_settings();
            end
            run_turn();
        end
    endtask

    // The receiver holds off while items keep coming, so the block backs up.
    task automatic test_output_stall();
        wait_idle();
        write_all(1440, 9920, 80, 60, 15, 2880, 3, 5000);
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
        send_item(make_item(OP_START, now_ms, 10'd0));
        for (int k = 0; k < 15; k++) begin
            now_ms += 16'd15;
            send_item(make_item(OP_SAMPLE, now_ms, 10'($urandom_range(600, 560))));
        end
    endtask

    initial begin
        turn_target = TARGET_RST;
        turn_bias = BIAS_RST;
        turn_gain = GAIN_RST;
        turn_max = MAX_RST;
        turn_min = MIN_RST;
        turn_limit = LIMIT_RST;
        turn_deadband = DEADBAND_RST;
        turn_timeout = TIMEOUT_RST;
        angle_sum = 0;
        last_rate = 0;
        last_ms = '0;
        turn_start_ms = '0;
        turn_over = 1'b1;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic(0, 0);
        test_random_traffic(57, 0);
        test_random_traffic(0, 57);
        test_output_stall();
        test_random_traffic(20, 20);

        wait_idle();
        repeat (12) @(posedge aclk);
        $display("Checked %0d results from %0d items over %0d turns (%0d reached the angle, %0d timed out).",
                 results_checked, items_sent, turns_started, angle_finishes, timeouts_seen);
        $display("Register extremes, crossed clamps, timestamp wrap, idling mixes and a long output stall were run.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
